// ----- rtl/core/spt_pkg.sv -----
// ----------------------------------------------------------------------------
// spt_pkg
// Shared types and constants of the Sv39 page-table walker.
// ----------------------------------------------------------------------------
package spt_pkg;

   localparam int MEM_WORDS  = 4096;
   localparam int PAGE_WORDS = 512;
   localparam int NUM_PAGES  = MEM_WORDS / PAGE_WORDS;
   localparam int ADDR_W     = $clog2(MEM_WORDS);
   localparam int PPN_W      = 44;
   localparam int ROOT_W     = 3;
   localparam int BIT_V      = 0;
   localparam int BIT_U      = 4;

   localparam logic [PPN_W-1:0] NUM_PAGES_PPN = PPN_W'(NUM_PAGES);

   typedef logic [ADDR_W-1:0] addr_type;

   typedef enum logic [1:0] {
      MODE_WRITE = 2'd0,
      MODE_READ  = 2'd1,
      MODE_XLATE = 2'd2,
      MODE_CLRU  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_VA_BIG       = 3'd1,
      ST_NO_TABLE     = 3'd2,
      ST_LEAF_INVALID = 3'd3,
      ST_NOT_USER     = 3'd4,
      ST_OUTSIDE      = 3'd5
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [55:0] phys_addr;
      logic        mapped;
      logic [63:0] read_data;
   } rsp_word_type;

endpackage

// ----- rtl/core/spt_ifs.sv -----
// ----------------------------------------------------------------------------
// spt_ifs
// Valid/ready channels for request and response words of the walker.
// ----------------------------------------------------------------------------
interface spt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [38:0] va;
   logic [11:0] word_index;
   logic [63:0] word_data;

   modport source (output valid, output mode, output va, output word_index,
                   output word_data, input ready);
   modport sink (input valid, input mode, input va, input word_index,
                 input word_data, output ready);
endinterface

interface spt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [55:0] phys_addr;
   logic        mapped;
   logic [63:0] read_data;

   modport source (output valid, output status, output phys_addr, output mapped,
                   output read_data, input ready);
   modport sink (input valid, input status, input phys_addr, input mapped,
                 input read_data, output ready);
endinterface

// ----- rtl/core/sv39_page_table_walker.sv -----
// ----------------------------------------------------------------------------
// sv39_page_table_walker
// Three-level Sv39 table walk over a local PTE memory.
// A leaf walk (translate or clear) steps through S_L2, S_L1 and S_L0 after acceptance,
// one dependent memory read per level; a table fault at level 2 or 1 ends it there.
// A word read answers from S_READ; a write and a fault found at acceptance from S_IDLE.
// One word is walked at a time; a waiting response does not hold off the next one.
// After reset all 4096 memory words are zeroed with the request channel not
// ready; root_page resets to 0.
// ----------------------------------------------------------------------------
module sv39_page_table_walker (
   input  logic                        clock,
   input  logic                        reset,
   spt_req_if.sink                     req_bus,
   spt_rsp_if.source                   rsp_bus,
   input  logic                        csr_we,
   input  logic [spt_pkg::ROOT_W-1:0]  csr_wdata
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_L2,
      S_L1,
      S_L0,
      S_OUT
   } state_type;

   state_type             state_ff, state_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   spt_pkg::rsp_word_type rsp_word_ff, rsp_word_in;
   spt_pkg::rsp_word_type pend_ff, pend_in;
   logic [38:0]           va_ff, va_in;
   logic                  clru_ff, clru_in;
   spt_pkg::addr_type     slot_ff, slot_in;
   spt_pkg::addr_type     clr_ff, clr_in;
   logic [spt_pkg::ROOT_W-1:0] root_ff, root_in;

   logic                  wr_en;
   spt_pkg::addr_type     wr_addr;
   logic [63:0]           wr_data;
   spt_pkg::addr_type     rd_addr;
   logic [63:0]           rd_data;

   spt_ram #(
      .DEPTH (spt_pkg::MEM_WORDS),
      .WIDTH (64)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_bus.ready     = (state_ff == S_IDLE);
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.status    = rsp_word_ff.status;
   assign rsp_bus.phys_addr = rsp_word_ff.phys_addr;
   assign rsp_bus.mapped    = rsp_word_ff.mapped;
   assign rsp_bus.read_data = rsp_word_ff.read_data;

   always_comb begin
      spt_pkg::rsp_word_type    res;
      logic                     fin;
      logic                     out_free;
      logic                     widx_out;
      logic [spt_pkg::PPN_W-1:0] ppn;
      logic [63:0]              pte;

      res          = '0;
      fin          = 1'b0;
      out_free     = !rsp_valid_ff || rsp_bus.ready;
      widx_out     = int'(req_bus.word_index) >= spt_pkg::MEM_WORDS;
      ppn          = rd_data[53:10];
      pte          = rd_data;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      pend_in      = pend_ff;
      va_in        = va_ff;
      clru_in      = clru_ff;
      slot_in      = slot_ff;
      clr_in       = clr_ff;
      root_in      = csr_we ? csr_wdata : root_ff;
      wr_en        = 1'b0;
      wr_addr      = slot_ff;
      wr_data      = '0;
      rd_addr      = '0;

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_bus.valid) begin
               va_in   = req_bus.va;
               clru_in = (req_bus.mode == spt_pkg::MODE_CLRU);
               case (req_bus.mode)
                  spt_pkg::MODE_WRITE: begin
                     fin = 1'b1;
                     if (widx_out) begin
                        res.status = spt_pkg::ST_OUTSIDE;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = spt_pkg::addr_type'(req_bus.word_index);
                        wr_data = req_bus.word_data;
                     end
                  end
                  spt_pkg::MODE_READ: begin
                     if (widx_out) begin
                        fin        = 1'b1;
                        res.status = spt_pkg::ST_OUTSIDE;
                     end else begin
                        rd_addr  = spt_pkg::addr_type'(req_bus.word_index);
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     if (req_bus.va[38]) begin
                        fin        = 1'b1;
                        res.status = spt_pkg::ST_VA_BIG;
                     end else if (int'(root_ff) >= spt_pkg::NUM_PAGES) begin
                        fin        = 1'b1;
                        res.status = spt_pkg::ST_OUTSIDE;
                     end else begin
                        rd_addr  = spt_pkg::addr_type'({root_ff, req_bus.va[38:30]});
                        state_in = S_L2;
                     end
                  end
               endcase
            end
         end
         S_READ: begin
            fin           = 1'b1;
            res.read_data = rd_data;
         end
         S_L2, S_L1: begin
            if (!rd_data[spt_pkg::BIT_V]) begin
               fin        = 1'b1;
               res.status = spt_pkg::ST_NO_TABLE;
            end else if (ppn >= spt_pkg::NUM_PAGES_PPN) begin
               fin        = 1'b1;
               res.status = spt_pkg::ST_OUTSIDE;
            end else if (state_ff == S_L2) begin
               rd_addr  = spt_pkg::addr_type'({ppn, va_ff[29:21]});
               state_in = S_L1;
            end else begin
               rd_addr  = spt_pkg::addr_type'({ppn, va_ff[20:12]});
               slot_in  = rd_addr;
               state_in = S_L0;
            end
         end
         S_L0: begin
            fin = 1'b1;
            if (clru_ff) begin
               pte[spt_pkg::BIT_U] = 1'b0;
               wr_en   = 1'b1;
               wr_addr = slot_ff;
               wr_data = pte;
            end else if (!pte[spt_pkg::BIT_V]) begin
               res.status = spt_pkg::ST_LEAF_INVALID;
            end else if (!pte[spt_pkg::BIT_U]) begin
               res.status = spt_pkg::ST_NOT_USER;
            end else begin
               res.phys_addr = {ppn, 12'd0};
            end
            res.mapped    = pte[spt_pkg::BIT_V];
            res.read_data = pte;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_word_in = pend_ff;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == S_OUT && out_free) begin
         rsp_valid_in = 1'b1;
      end
      if (fin) begin
         if (out_free) begin
            rsp_word_in  = res;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end else begin
            pend_in  = res;
            state_in = S_OUT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
         clr_ff       <= '0;
         root_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_ff       <= clr_in;
         root_ff      <= root_in;
      end
      rsp_word_ff <= rsp_word_in;
      pend_ff     <= pend_in;
      va_ff       <= va_in;
      clru_ff     <= clru_in;
      slot_ff     <= slot_in;
   end

endmodule

// ----- rtl/core/spt_ram.sv -----
// ----------------------------------------------------------------------------
// spt_ram
// Simple dual-port synchronous RAM with one write port and one registered
// read port.
// ----------------------------------------------------------------------------
module spt_ram #(
   parameter int DEPTH = spt_pkg::MEM_WORDS,
   parameter int WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- rtl/core/spt_checker.sv -----
// ----------------------------------------------------------------------------
// spt_checker
// Port-level checks of the page-table walker, bound to the top level.
// ----------------------------------------------------------------------------
module spt_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   logic [1:0] open_ff, open_in;
   logic       req_take;
   logic       rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   always_comb begin
      open_in = open_ff;
      if (req_take && !rsp_take) begin
         open_in = open_ff + 2'd1;
      end else if (rsp_take && !req_take) begin
         open_in = open_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   // The memory clearing pass keeps requests out right after reset.
   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_ready)
      else $error("request accepted during the memory clearing pass");

   // At most one word in the walk and one waiting at the output.
   a_open_bound: assert property (@(posedge clock) disable iff (reset)
      open_ff <= 2'd2)
      else $error("more than two words outstanding");

   // Every response belongs to an earlier accepted request.
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != 2'd0)
      else $error("response without an outstanding request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

endmodule

bind sv39_page_table_walker spt_checker u_spt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready)
);

// ----- test/tb_sv39_page_table_walker.sv -----
// ----------------------------------------------------------------------------
// tb_sv39_page_table_walker
// Self-checking bench for the Sv39 page-table walker. A local mirror of the
// PTE memory and of root_page computes the response for every request word.
// Directed tests cover word access, every walk fault and the user-bit clear.
// Random traffic then builds three-level table paths and walks them under
// several root pages, with random idle bursts on both channels in all but the last phase.
// ----------------------------------------------------------------------------
module tb_sv39_page_table_walker;

   localparam int STALL_LIMIT = 20000;
   localparam int PHASE_WORDS = 206;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   logic [spt_pkg::ROOT_W-1:0] csr_wdata;

   spt_req_if req_bus ();
   spt_rsp_if rsp_bus ();

   sv39_page_table_walker dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   logic [63:0] pte_mirror [spt_pkg::MEM_WORDS];
   logic [spt_pkg::ROOT_W-1:0] root_mirror;
   spt_pkg::rsp_word_type rsp_due [$];
   logic [38:0] recent_va [8];
   int unsigned recent_ptr;
   bit idle_en;
   int unsigned sent_words;
   int unsigned checked_words;
   int unsigned root_writes;
   int unsigned error_count;
   int unsigned status_seen [8];
   int unsigned stall_left;
   int unsigned quiet_cycles;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic spt_pkg::rsp_word_type walk_outcome(spt_pkg::mode_type m,
                                                          logic [38:0] va,
                                                          logic [11:0] idx,
                                                          logic [63:0] data);
      spt_pkg::rsp_word_type r;
      logic [spt_pkg::PPN_W-1:0] page;
      logic [8:0] vpn;
      logic [63:0] pte;
      int slot;
      bit reached;
      r = '0;
      r.status = spt_pkg::ST_OK;
      reached = 1'b0;
      slot = 0;
      if (m == spt_pkg::MODE_WRITE || m == spt_pkg::MODE_READ) begin
         if (int'(idx) >= spt_pkg::MEM_WORDS) begin
            r.status = spt_pkg::ST_OUTSIDE;
         end else if (m == spt_pkg::MODE_WRITE) begin
            pte_mirror[idx] = data;
         end else begin
            r.read_data = pte_mirror[idx];
         end
      end else if (va[38]) begin
         r.status = spt_pkg::ST_VA_BIG;
      end else begin
         page = spt_pkg::PPN_W'(root_mirror);
         for (int lvl = 2; lvl >= 0; lvl--) begin
            vpn = va[12 + 9 * lvl +: 9];
            if (page >= spt_pkg::NUM_PAGES_PPN) begin
               r.status = spt_pkg::ST_OUTSIDE;
               break;
            end
            slot = int'(page) * spt_pkg::PAGE_WORDS + int'(vpn);
            if (lvl == 0) begin
               reached = 1'b1;
            end else if (!pte_mirror[slot][spt_pkg::BIT_V]) begin
               r.status = spt_pkg::ST_NO_TABLE;
               break;
            end else begin
               page = pte_mirror[slot][53:10];
            end
         end
         if (reached) begin
            pte = pte_mirror[slot];
            if (m == spt_pkg::MODE_XLATE) begin
               r.mapped = pte[spt_pkg::BIT_V];
               if (!pte[spt_pkg::BIT_V]) begin
                  r.status = spt_pkg::ST_LEAF_INVALID;
               end else if (!pte[spt_pkg::BIT_U]) begin
                  r.status = spt_pkg::ST_NOT_USER;
               end else begin
                  r.phys_addr = {pte[53:10], 12'h000};
               end
            end else begin
               pte[spt_pkg::BIT_U] = 1'b0;
               pte_mirror[slot] = pte;
               r.mapped = pte[spt_pkg::BIT_V];
            end
            r.read_data = pte;
         end
      end
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [38:0] rand_va();
      return 39'(rand64());
   endfunction

   function automatic logic [38:0] sv39_va(logic [8:0] i2, logic [8:0] i1, logic [8:0] i0,
                                           logic [11:0] offs);
      return {i2, i1, i0, offs};
   endfunction

   function automatic logic [63:0] table_pte(logic [spt_pkg::PPN_W-1:0] ppn);
      logic [63:0] p;
      p = rand64();
      p[53:10] = ppn;
      p[spt_pkg::BIT_V] = 1'b1;
      return p;
   endfunction

   function automatic logic [63:0] leaf_pte(logic v, logic u,
                                            logic [spt_pkg::PPN_W-1:0] ppn);
      logic [63:0] p;
      p = rand64();
      p[53:10] = ppn;
      p[spt_pkg::BIT_V] = v;
      p[spt_pkg::BIT_U] = u;
      return p;
   endfunction

   function automatic logic [spt_pkg::PPN_W-1:0] pick_table_page();
      if ($urandom_range(0, 9) == 0) begin
         return spt_pkg::PPN_W'(rand64()) | spt_pkg::PPN_W'(spt_pkg::NUM_PAGES);
      end
      return spt_pkg::PPN_W'($urandom_range(0, spt_pkg::NUM_PAGES - 1));
   endfunction

   task automatic send_word(spt_pkg::mode_type m, logic [38:0] va, logic [11:0] idx,
                            logic [63:0] data);
      if (idle_en && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.mode       <= m;
      req_bus.va         <= va;
      req_bus.word_index <= idx;
      req_bus.word_data  <= data;
      do @(posedge clock); while (!req_bus.ready);
      rsp_due.push_back(walk_outcome(m, va, idx, data));
      sent_words++;
   endtask

   task automatic settle_block();
      req_bus.valid <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_root(logic [spt_pkg::ROOT_W-1:0] r);
      settle_block();
      csr_we    <= 1'b1;
      csr_wdata <= r;
      @(posedge clock);
      csr_we <= 1'b0;
      root_mirror = r;
      root_writes++;
   endtask

   task automatic test_word_access();
      send_word(spt_pkg::MODE_WRITE, '0, 12'hFFF, '1);
      send_word(spt_pkg::MODE_READ, '0, 12'hFFF, '0);
      send_word(spt_pkg::MODE_WRITE, '0, 12'h000, 64'h5A5A_F0F0_0FF0_A5A4);
      send_word(spt_pkg::MODE_READ, '1, 12'h000, '1);
   endtask

   task automatic test_walk_faults();
      send_word(spt_pkg::MODE_XLATE, '1, '0, '0);
      send_word(spt_pkg::MODE_CLRU, 39'h40_0000_0000, '0, '0);
      send_word(spt_pkg::MODE_XLATE, sv39_va(9'd5, 9'd0, 9'd0, 12'h000), '0, '0);
      send_word(spt_pkg::MODE_WRITE, '0, {3'd0, 9'd1}, table_pte(44'd2));
      send_word(spt_pkg::MODE_XLATE, sv39_va(9'd1, 9'd3, 9'd7, 12'hABC), '0, '0);
      send_word(spt_pkg::MODE_WRITE, '0, {3'd2, 9'd3}, table_pte(44'd3));
      send_word(spt_pkg::MODE_XLATE, sv39_va(9'd1, 9'd3, 9'd7, 12'hABC), '0, '0);
      send_word(spt_pkg::MODE_WRITE, '0, {3'd3, 9'd7},
                leaf_pte(1'b1, 1'b0, spt_pkg::PPN_W'(rand64())));
      send_word(spt_pkg::MODE_XLATE, sv39_va(9'd1, 9'd3, 9'd7, 12'h000), '0, '0);
      send_word(spt_pkg::MODE_WRITE, '0, {3'd0, 9'd9},
                table_pte(spt_pkg::PPN_W'(spt_pkg::NUM_PAGES)));
      send_word(spt_pkg::MODE_XLATE, sv39_va(9'd9, 9'd0, 9'd0, 12'h000), '0, '0);
      send_word(spt_pkg::MODE_WRITE, '0, {3'd2, 9'd4}, table_pte('1));
      send_word(spt_pkg::MODE_XLATE, sv39_va(9'd1, 9'd4, 9'd0, 12'h000), '0, '0);
   endtask

   task automatic test_clear_user();
      send_word(spt_pkg::MODE_WRITE, '0, {3'd3, 9'd7}, leaf_pte(1'b1, 1'b1, '1));
      send_word(spt_pkg::MODE_XLATE, sv39_va(9'd1, 9'd3, 9'd7, 12'hFFF), '0, '0);
      send_word(spt_pkg::MODE_CLRU, sv39_va(9'd1, 9'd3, 9'd7, 12'h000), '0, '0);
      send_word(spt_pkg::MODE_XLATE, sv39_va(9'd1, 9'd3, 9'd7, 12'h000), '0, '0);
      send_word(spt_pkg::MODE_CLRU, sv39_va(9'd1, 9'd3, 9'd8, 12'h000), '0, '0);
   endtask

   // Builds one full path from the root to a leaf, sometimes leaving a level
   // out, and then walks it once or twice.
   task automatic random_walk();
      logic [38:0] va;
      logic [spt_pkg::PPN_W-1:0] p1;
      logic [spt_pkg::PPN_W-1:0] p2;
      spt_pkg::mode_type m;
      va = rand_va();
      va[38] = 1'b0;
      p1 = pick_table_page();
      p2 = pick_table_page();
      if ($urandom_range(0, 7) != 0) begin
         send_word(spt_pkg::MODE_WRITE, rand_va(), {root_mirror, va[38:30]}, table_pte(p1));
      end
      if ($urandom_range(0, 7) != 0) begin
         send_word(spt_pkg::MODE_WRITE, rand_va(), {p1[2:0], va[29:21]}, table_pte(p2));
      end
      if ($urandom_range(0, 7) != 0) begin
         send_word(spt_pkg::MODE_WRITE, rand_va(), {p2[2:0], va[20:12]},
                   leaf_pte($urandom_range(0, 5) != 0, $urandom_range(0, 3) != 0,
                            spt_pkg::PPN_W'(rand64())));
      end
      repeat ($urandom_range(1, 2)) begin
         m = ($urandom_range(0, 2) == 0) ? spt_pkg::MODE_CLRU : spt_pkg::MODE_XLATE;
         send_word(m, va, 12'($urandom()), rand64());
      end
      if ($urandom_range(0, 3) == 0) begin
         send_word(spt_pkg::MODE_READ, rand_va(), {p2[2:0], va[20:12]}, rand64());
      end
      recent_va[recent_ptr[2:0]] = va;
      recent_ptr++;
   endtask

   task automatic random_item();
      int unsigned sel;
      spt_pkg::mode_type m;
      sel = $urandom_range(0, 9);
      m = ($urandom_range(0, 1) == 0) ? spt_pkg::MODE_CLRU : spt_pkg::MODE_XLATE;
      if (sel < 6) begin
         random_walk();
      end else if (sel == 6) begin
         send_word(spt_pkg::MODE_WRITE, rand_va(), 12'($urandom()), rand64());
      end else if (sel == 7) begin
         send_word(spt_pkg::MODE_READ, rand_va(), 12'($urandom()), rand64());
      end else if (sel == 8) begin
         send_word(m, rand_va(), 12'($urandom()), rand64());
      end else begin
         send_word(m, recent_va[$urandom_range(0, 7)] ^ 39'($urandom_range(0, 4095)),
                   12'($urandom()), rand64());
      end
   endtask

   task automatic test_random_traffic();
      int unsigned stop_at;
      for (int ph = 0; ph < 5; ph++) begin
         if (ph == 4) begin
            idle_en = 1'b0;
         end
         if (ph == 0) begin
            set_root('1);
         end else if (ph == 1) begin
            set_root('0);
         end else begin
            set_root(spt_pkg::ROOT_W'($urandom()));
         end
         stop_at = sent_words + PHASE_WORDS;
         while (sent_words < stop_at) random_item();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         stall_left--;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left = $urandom_range(0, 11);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      spt_pkg::rsp_word_type due;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (rsp_due.size() == 0) begin
            $error("response word with nothing outstanding");
            error_count++;
         end else begin
            due = rsp_due.pop_front();
            checked_words++;
            status_seen[due.status]++;
            if (rsp_bus.status !== due.status) begin
               $error("status: expected %0d, got %0d", due.status, rsp_bus.status);
               error_count++;
            end
            if (rsp_bus.phys_addr !== due.phys_addr) begin
               $error("phys_addr: expected %h, got %h", due.phys_addr, rsp_bus.phys_addr);
               error_count++;
            end
            if (rsp_bus.mapped !== due.mapped) begin
               $error("mapped: expected %0d, got %0d", due.mapped, rsp_bus.mapped);
               error_count++;
            end
            if (rsp_bus.read_data !== due.read_data) begin
               $error("read_data: expected %h, got %h", due.read_data, rsp_bus.read_data);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("Timed out after %0d cycles without a word moving.", STALL_LIMIT);
            $display("tb_sv39_page_table_walker: done, errors");
            $finish;
         end
      end
   end

   initial begin
      req_bus.valid      = 1'b0;
      req_bus.mode       = spt_pkg::MODE_WRITE;
      req_bus.va         = '0;
      req_bus.word_index = '0;
      req_bus.word_data  = '0;
      csr_we             = 1'b0;
      csr_wdata          = '0;
      root_mirror        = '0;
      idle_en            = 1'b1;
      foreach (pte_mirror[i]) pte_mirror[i] = '0;
      foreach (recent_va[i]) recent_va[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (!req_bus.ready);

      test_word_access();
      test_walk_faults();
      test_clear_user();
      test_random_traffic();
      settle_block();

      $display("Sent %0d request words and checked %0d responses under %0d root settings.",
               sent_words, checked_words, root_writes);
      $display("Statuses seen: ok %0d, va %0d, no table %0d, invalid %0d, user %0d, out %0d.",
               status_seen[spt_pkg::ST_OK], status_seen[spt_pkg::ST_VA_BIG],
               status_seen[spt_pkg::ST_NO_TABLE], status_seen[spt_pkg::ST_LEAF_INVALID],
               status_seen[spt_pkg::ST_NOT_USER], status_seen[spt_pkg::ST_OUTSIDE]);
      if (rsp_due.size() != 0) begin
         $error("%0d responses never arrived", rsp_due.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("tb_sv39_page_table_walker: done, clean");
      end else begin
         $display("tb_sv39_page_table_walker: done, errors");
      end
      $finish;
   end

endmodule
